@@ design/assert_macros.svh @@
// Assertion macros for design files that check themselves.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checks that a condition holds at every clock edge outside reset.
`define KMH_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Checks that a condition in one cycle implies another in the next cycle.
`define KMH_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`endif

@@ design/kmh_pkg.sv @@
// Shared types, constants and state encoding for the spanning tree core.
`timescale 1ns / 1ps
package kmh_pkg;
    localparam int VERTEX_COUNT_DEF  = 64;
    localparam int EDGE_CAPACITY_DEF = 128;
    localparam int VERTEX_W          = 6;
    localparam int WEIGHT_W          = 16;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [VERTEX_W-1:0] to_v;
        logic [VERTEX_W-1:0] from_v;
    } kmh_edge_t;

    // Requests from the sequencer to the union-find parent store.
    typedef struct packed {
        logic                clear;
        logic                rd_en;
        logic [VERTEX_W-1:0] rd_addr;
        logic                wr_en;
        logic [VERTEX_W-1:0] wr_addr;
        logic [VERTEX_W-1:0] wr_data;
    } kmh_pa_req_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PUSH_CHK,
        S_PUSH_CMP,
        S_NEXT,
        S_POP_RD1,
        S_POP_RDL,
        S_POP_LAST,
        S_SD_CHK,
        S_SD_K1,
        S_SD_K2,
        S_SD_DEC,
        S_VCHK,
        S_FA,
        S_FA_W,
        S_FB,
        S_FB_W,
        S_LINK,
        S_FLUSH
    } kmh_state_t;
endpackage

@@ design/kmh_parent_store.sv @@
// Union-find parent store: a synchronous memory with one valid bit per vertex.
`timescale 1ns / 1ps
module kmh_parent_store #(
    parameter int VERTEX_COUNT = kmh_pkg::VERTEX_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  kmh_pkg::kmh_pa_req_t          req,
    output logic                          linked,
    output logic [kmh_pkg::VERTEX_W-1:0]  parent
);
    import kmh_pkg::*;

    localparam int VW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;

    logic [VW-1:0]           parent_mem [VERTEX_COUNT];
    logic [VERTEX_COUNT-1:0] valid_reg;
    logic                    linked_reg;
    logic [VW-1:0]           parent_reg;

    // A vertex without its valid bit has no parent and is its own root.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.clear)
        begin
            valid_reg <= '0;
        end
        else if (req.wr_en)
        begin
            valid_reg[req.wr_addr[VW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            parent_mem[req.wr_addr[VW-1:0]] <= req.wr_data[VW-1:0];
        end
        if (req.rd_en)
        begin
            linked_reg <= valid_reg[req.rd_addr[VW-1:0]];
            parent_reg <= parent_mem[req.rd_addr[VW-1:0]];
        end
    end

    assign linked = linked_reg;
    assign parent = VERTEX_W'(parent_reg);
endmodule

@@ design/kruskal_mst_min_heap_core.sv @@
// Top level: heap-ordered edge store and Kruskal sequencer with stream ports.
// Load: an edge rises level by level, reading the parent slot and then writing one slot per level.
// Run: each pop reads the root and the last entry, sifts down level by level, then finds each endpoint's root.
// These steps wait on the registered reads of the heap memory and of the parent store.
// Reset (rst_n, asynchronous, low) empties the heap and clears all parent links at once.
// Results stay one behind: the last tree edge is held until the heap runs empty.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module kruskal_mst_min_heap_core #(
    parameter int VERTEX_COUNT  = kmh_pkg::VERTEX_COUNT_DEF,
    parameter int EDGE_CAPACITY = kmh_pkg::EDGE_CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // from_vertex[5:0], to_vertex[11:6], edge_weight[27:12], zeros
    input  logic        s_tlast,  // final_edge
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // tree_from[5:0], tree_to[11:6], tree_weight[27:12], zeros
    output logic [1:0]  m_tuser,  // edge_present[0], overflowed[1]
    output logic        m_tlast   // run_end
);
    import kmh_pkg::*;

    localparam int AW = $clog2(EDGE_CAPACITY + 1);
    localparam int VW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;

    // Heap memory, 1-based; entry 0 is never used.
    kmh_edge_t heap_mem [EDGE_CAPACITY + 1];
    kmh_edge_t hr_data_reg;
    logic      hr_en, hw_en;
    logic [AW-1:0] hr_addr, hw_addr;
    kmh_edge_t hw_data;

    kmh_state_t state_reg, state_next;
    logic [AW-1:0] count_reg, count_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] up_reg, up_next;
    logic [AW-1:0] kidsel_reg, kidsel_next;
    logic          drop_reg, drop_next;
    logic          final_reg, final_next;
    logic          pend_valid_reg, pend_valid_next;
    logic          out_valid_reg, out_valid_next;
    kmh_edge_t     new_reg, new_next;
    kmh_edge_t     top_reg, top_next;
    kmh_edge_t     last_reg, last_next;
    kmh_edge_t     left_reg, left_next;
    kmh_edge_t     child_reg, child_next;
    kmh_edge_t     pend_reg, pend_next;
    kmh_edge_t     out_edge_reg, out_edge_next;
    logic          out_present_reg, out_present_next;
    logic          out_ovf_reg, out_ovf_next;
    logic          out_end_reg, out_end_next;
    logic [VW-1:0] v_reg, v_next;
    logic [VW-1:0] ra_reg, ra_next;
    logic [VW-1:0] rb_reg, rb_next;

    kmh_pa_req_t pa_req;
    logic        pa_linked;
    logic [VERTEX_W-1:0] pa_parent;

    logic [AW:0] kid;
    logic        in_accept, out_free;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign kid       = {up_reg, 1'b0};

    kmh_parent_store #(
        .VERTEX_COUNT(VERTEX_COUNT)
    ) u_parent (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (pa_req),
        .linked (pa_linked),
        .parent (pa_parent)
    );

    always_ff @(posedge clk)
    begin
        if (hw_en)
        begin
            heap_mem[hw_addr] <= hw_data;
        end
        if (hr_en)
        begin
            hr_data_reg <= heap_mem[hr_addr];
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        pos_next         = pos_reg;
        up_next          = up_reg;
        kidsel_next      = kidsel_reg;
        drop_next        = drop_reg;
        final_next       = final_reg;
        pend_valid_next  = pend_valid_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        new_next         = new_reg;
        top_next         = top_reg;
        last_next        = last_reg;
        left_next        = left_reg;
        child_next       = child_reg;
        pend_next        = pend_reg;
        out_edge_next    = out_edge_reg;
        out_present_next = out_present_reg;
        out_ovf_next     = out_ovf_reg;
        out_end_next     = out_end_reg;
        v_next           = v_reg;
        ra_next          = ra_reg;
        rb_next          = rb_reg;
        hr_en   = 1'b0;
        hr_addr = '0;
        hw_en   = 1'b0;
        hw_addr = '0;
        hw_data = new_reg;
        pa_req  = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    new_next   = kmh_edge_t'(s_tdata[27:0]);
                    final_next = s_tlast;
                    if (count_reg < AW'(EDGE_CAPACITY))
                    begin
                        count_next = count_reg + 1'b1;
                        pos_next   = count_reg + 1'b1;
                        state_next = S_PUSH_CHK;
                    end
                    else
                    begin
                        drop_next  = 1'b1;
                        state_next = s_tlast ? S_NEXT : S_IDLE;
                    end
                    // A new run starts with every vertex its own root.
                    pa_req.clear = s_tlast;
                end
            end
            S_PUSH_CHK:
            begin
                if (pos_reg == AW'(1))
                begin
                    hw_en      = 1'b1;
                    hw_addr    = pos_reg;
                    hw_data    = new_reg;
                    state_next = final_reg ? S_NEXT : S_IDLE;
                end
                else
                begin
                    hr_en      = 1'b1;
                    hr_addr    = pos_reg >> 1;
                    state_next = S_PUSH_CMP;
                end
            end
            S_PUSH_CMP:
            begin
                hw_en   = 1'b1;
                hw_addr = pos_reg;
                // The parent moves down only while the new weight is strictly smaller.
                if (new_reg.weight < hr_data_reg.weight)
                begin
                    hw_data    = hr_data_reg;
                    pos_next   = pos_reg >> 1;
                    state_next = S_PUSH_CHK;
                end
                else
                begin
                    hw_data    = new_reg;
                    state_next = final_reg ? S_NEXT : S_IDLE;
                end
            end
            S_NEXT:
            begin
                state_next = (count_reg == '0) ? S_FLUSH : S_POP_RD1;
            end
            S_POP_RD1:
            begin
                hr_en      = 1'b1;
                hr_addr    = AW'(1);
                state_next = S_POP_RDL;
            end
            S_POP_RDL:
            begin
                top_next   = hr_data_reg;
                hr_en      = 1'b1;
                hr_addr    = count_reg;
                state_next = S_POP_LAST;
            end
            S_POP_LAST:
            begin
                last_next  = hr_data_reg;
                count_next = count_reg - 1'b1;
                up_next    = AW'(1);
                state_next = S_SD_CHK;
            end
            S_SD_CHK:
            begin
                if (kid > {1'b0, count_reg})
                begin
                    hw_en      = 1'b1;
                    hw_addr    = up_reg;
                    hw_data    = last_reg;
                    state_next = S_VCHK;
                end
                else
                begin
                    hr_en      = 1'b1;
                    hr_addr    = kid[AW-1:0];
                    state_next = S_SD_K1;
                end
            end
            S_SD_K1:
            begin
                left_next   = hr_data_reg;
                child_next  = hr_data_reg;
                kidsel_next = kid[AW-1:0];
                if (kid < {1'b0, count_reg})
                begin
                    hr_en      = 1'b1;
                    hr_addr    = kid[AW-1:0] + 1'b1;
                    state_next = S_SD_K2;
                end
                else
                begin
                    state_next = S_SD_DEC;
                end
            end
            S_SD_K2:
            begin
                // The right child wins only when the left one is strictly heavier.
                if (left_reg.weight > hr_data_reg.weight)
                begin
                    child_next  = hr_data_reg;
                    kidsel_next = kidsel_reg + 1'b1;
                end
                state_next = S_SD_DEC;
            end
            S_SD_DEC:
            begin
                hw_en   = 1'b1;
                hw_addr = up_reg;
                if (last_reg.weight <= child_reg.weight)
                begin
                    hw_data    = last_reg;
                    state_next = S_VCHK;
                end
                else
                begin
                    hw_data    = child_reg;
                    up_next    = kidsel_reg;
                    state_next = S_SD_CHK;
                end
            end
            S_VCHK:
            begin
                // An edge with an endpoint outside the graph is discarded.
                if ({1'b0, top_reg.from_v} >= (VERTEX_W + 1)'(VERTEX_COUNT) ||
                    {1'b0, top_reg.to_v} >= (VERTEX_W + 1)'(VERTEX_COUNT))
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    v_next     = top_reg.from_v[VW-1:0];
                    state_next = S_FA;
                end
            end
            S_FA:
            begin
                pa_req.rd_en   = 1'b1;
                pa_req.rd_addr = VERTEX_W'(v_reg);
                state_next     = S_FA_W;
            end
            S_FA_W:
            begin
                if (pa_linked)
                begin
                    v_next     = pa_parent[VW-1:0];
                    state_next = S_FA;
                end
                else
                begin
                    ra_next    = v_reg;
                    v_next     = top_reg.to_v[VW-1:0];
                    state_next = S_FB;
                end
            end
            S_FB:
            begin
                pa_req.rd_en   = 1'b1;
                pa_req.rd_addr = VERTEX_W'(v_reg);
                state_next     = S_FB_W;
            end
            S_FB_W:
            begin
                if (pa_linked)
                begin
                    v_next     = pa_parent[VW-1:0];
                    state_next = S_FB;
                end
                else
                begin
                    rb_next    = v_reg;
                    state_next = S_LINK;
                end
            end
            S_LINK:
            begin
                if (ra_reg == rb_reg)
                begin
                    state_next = S_NEXT;
                end
                else if (!pend_valid_reg || out_free)
                begin
                    pa_req.wr_en   = 1'b1;
                    pa_req.wr_addr = VERTEX_W'(ra_reg);
                    pa_req.wr_data = VERTEX_W'(rb_reg);
                    if (pend_valid_reg)
                    begin
                        out_valid_next   = 1'b1;
                        out_edge_next    = pend_reg;
                        out_present_next = 1'b1;
                        out_ovf_next     = drop_reg;
                        out_end_next     = 1'b0;
                    end
                    pend_next       = top_reg;
                    pend_valid_next = 1'b1;
                    state_next      = S_NEXT;
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_edge_next    = pend_valid_reg ? pend_reg : '0;
                    out_present_next = pend_valid_reg;
                    out_ovf_next     = drop_reg;
                    out_end_next     = 1'b1;
                    pend_valid_next  = 1'b0;
                    drop_next        = 1'b0;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            drop_reg       <= 1'b0;
            final_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            drop_reg       <= drop_next;
            final_reg      <= final_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg         <= pos_next;
        up_reg          <= up_next;
        kidsel_reg      <= kidsel_next;
        new_reg         <= new_next;
        top_reg         <= top_next;
        last_reg        <= last_next;
        left_reg        <= left_next;
        child_reg       <= child_next;
        pend_reg        <= pend_next;
        out_edge_reg    <= out_edge_next;
        out_present_reg <= out_present_next;
        out_ovf_reg     <= out_ovf_next;
        out_end_reg     <= out_end_next;
        v_reg           <= v_next;
        ra_reg          <= ra_next;
        rb_reg          <= rb_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_edge_reg};
    assign m_tuser  = {out_ovf_reg, out_present_reg};
    assign m_tlast  = out_end_reg;

    // Popping the only edge still writes it back to the root slot of the now empty heap.
    `KMH_ASSERT(a_count_bound, count_reg <= AW'(EDGE_CAPACITY), "heap count above capacity")
    `KMH_ASSERT(a_heap_addr,
        !hw_en || (hw_addr != '0 && (hw_addr <= count_reg || hw_addr == AW'(1))),
        "heap write outside live entries")
    `KMH_ASSERT_NEXT(a_drop_full, in_accept && count_reg == AW'(EDGE_CAPACITY), drop_reg,
        "full heap did not flag drop")
    `KMH_ASSERT_NEXT(a_flush_idle, state_reg == S_FLUSH && out_free,
        state_reg == S_IDLE && m_tvalid && m_tlast && !pend_valid_reg,
        "run end not delivered")
endmodule
